// ===== hdl/drh_pkg.sv =====
// drh_pkg: sizes, codes, types and helper functions of the duplicate run histogram
// used by drh_hist_mem and duplicate_run_histogram; no dependencies

package drh_pkg;

    localparam int HIST_BINS     = 64;
    localparam int COUNT_BITS    = 32;
    localparam int BIN_BITS      = $clog2(HIST_BINS);
    localparam int IN_DATA_BITS  = 80;
    localparam int OUT_DATA_BITS = 72;

    // result status codes
    localparam logic [1:0] STATUS_ACCEPTED = 2'd0;
    localparam logic [1:0] STATUS_UNSORTED = 2'd1;
    localparam logic [1:0] STATUS_BIN      = 2'd2;

    // input kind codes
    localparam logic KIND_READ  = 1'b0;
    localparam logic KIND_FLUSH = 1'b1;

    // one histogram access: en starts a read, inc also writes back count + 1
    typedef struct packed {
        logic                en;
        logic                inc;
        logic [BIN_BITS-1:0] addr;
    } hist_req_t;

    // bin that a finished run of the given length counts in
    function automatic logic [BIN_BITS-1:0] bin_of(input logic [31:0] run_len);
        logic [BIN_BITS-1:0] result;
        if (run_len > 32'(HIST_BINS - 1)) begin
            result = BIN_BITS'(HIST_BINS - 1);
        end else begin
            result = run_len[BIN_BITS-1:0];
        end
        return result;
    endfunction

    // histogram count as seen on the 32 bit result field
    function automatic logic [31:0] count_out(input logic [COUNT_BITS-1:0] cnt);
        logic [63:0] wide;
        wide = 64'(cnt);
        return wide[31:0];
    endfunction

    function automatic logic [31:0] sat_inc32(input logic [31:0] value);
        logic [31:0] result;
        if (value == 32'hFFFF_FFFF) begin
            result = value;
        end else begin
            result = value + 32'd1;
        end
        return result;
    endfunction

endpackage

// ===== hdl/duplicate_run_histogram.sv =====
// duplicate_run_histogram: top level, read compare, run tracking, flush dump sequencer
// and result register; uses drh_pkg and drh_hist_mem

// A read transaction's result is loaded into the single output register the cycle it
// is accepted, and a new input transaction is taken whenever that register is empty or
// being drained. When a run closes, its bin is read from the histogram ram and the
// incremented count written back the next cycle, with forwarding so that closing runs
// on consecutive reads keep the one per cycle rate while the output does not stall. A
// flush transaction dumps the bins in order: each bin is read from the ram in S_DUMP_RD
// and then loaded into the output register in S_DUMP_OUT, and output stalls hold the
// dump. No input is taken during the dump. Bins are zero after reset through per-bin
// valid bits, so there is no clearing pass.

module duplicate_run_histogram (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               cfg_wr_en,
    input  logic                               cfg_wr_data,   // paired_mode
    input  logic                               s_tvalid,
    output logic                               s_tready,
    // chrom_index [9:0], start coordinate [41:10], end coordinate [73:42], zero [79:74]
    input  logic [drh_pkg::IN_DATA_BITS-1:0]   s_tdata,
    input  logic                               s_tuser,       // kind
    output logic                               m_tvalid,
    input  logic                               m_tready,
    // bin_index [5:0], bin_count [37:6], total_reads [69:38], zero [71:70]
    output logic [drh_pkg::OUT_DATA_BITS-1:0]  m_tdata,
    output logic [1:0]                         m_tuser,       // status
    output logic                               m_tlast
);

    typedef enum logic [2:0] {
        S_RUN      = 3'b001,
        S_DUMP_RD  = 3'b010,
        S_DUMP_OUT = 3'b100
    } state_t;

    state_t state_reg, state_next;

    logic                         paired_mode_reg;
    logic [9:0]                   prev_chrom_reg, prev_chrom_next;
    logic [31:0]                  prev_start_reg, prev_start_next;
    logic [31:0]                  prev_end_reg, prev_end_next;
    logic                         have_prev_reg, have_prev_next;
    logic [31:0]                  run_length_reg, run_length_next;
    logic [31:0]                  read_total_reg, read_total_next;
    logic [drh_pkg::BIN_BITS-1:0] dump_idx_reg, dump_idx_next;

    logic                         m_tvalid_reg, m_tvalid_next;
    logic [1:0]                   out_status_reg, out_status_next;
    logic [5:0]                   out_bin_reg, out_bin_next;
    logic [31:0]                  out_count_reg, out_count_next;
    logic [31:0]                  out_total_reg, out_total_next;
    logic                         out_last_reg, out_last_next;

    logic                         in_kind;
    logic [9:0]                   in_chrom;
    logic [31:0]                  in_start;
    logic [31:0]                  in_end;
    logic                         in_accept;
    logic                         out_free;
    logic                         chrom_match;
    logic                         unsorted;
    logic                         read_match;
    logic [31:0]                  read_total_inc;
    logic                         dump_last;

    drh_pkg::hist_req_t             hist_req;
    logic                           hist_clear;
    logic [drh_pkg::COUNT_BITS-1:0] hist_count;

    drh_hist_mem u_hist_mem (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .req       (hist_req),
        .clear_all (hist_clear),
        .old_count (hist_count)
    );

    assign in_kind  = s_tuser;
    assign in_chrom = s_tdata[9:0];
    assign in_start = s_tdata[41:10];
    assign in_end   = s_tdata[73:42];

    assign out_free  = !m_tvalid_reg || m_tready;
    assign s_tready  = (state_reg == S_RUN) && out_free;
    assign in_accept = s_tvalid && s_tready;

    assign chrom_match = (in_chrom == prev_chrom_reg);
    assign unsorted    = chrom_match && (in_start < prev_start_reg) &&
                         (!paired_mode_reg || (in_end < prev_end_reg));
    assign read_match  = chrom_match && (in_start == prev_start_reg) &&
                         (!paired_mode_reg || (in_end == prev_end_reg));
    assign read_total_inc = drh_pkg::sat_inc32(read_total_reg);
    assign dump_last      = (dump_idx_reg == drh_pkg::BIN_BITS'(drh_pkg::HIST_BINS - 1));

    always_comb begin
        state_next      = state_reg;
        prev_chrom_next = prev_chrom_reg;
        prev_start_next = prev_start_reg;
        prev_end_next   = prev_end_reg;
        have_prev_next  = have_prev_reg;
        run_length_next = run_length_reg;
        read_total_next = read_total_reg;
        dump_idx_next   = dump_idx_reg;
        m_tvalid_next   = m_tvalid_reg;
        out_status_next = out_status_reg;
        out_bin_next    = out_bin_reg;
        out_count_next  = out_count_reg;
        out_total_next  = out_total_reg;
        out_last_next   = out_last_reg;
        hist_req        = '0;
        hist_clear      = 1'b0;

        if (m_tready) begin
            m_tvalid_next = 1'b0;
        end

        case (state_reg)
            S_RUN: begin
                if (in_accept) begin
                    if (in_kind == drh_pkg::KIND_FLUSH) begin
                        // close the open run before the dump starts
                        hist_req.en   = have_prev_reg;
                        hist_req.inc  = 1'b1;
                        hist_req.addr = drh_pkg::bin_of(run_length_reg);
                        dump_idx_next = '0;
                        state_next    = S_DUMP_RD;
                    end else begin
                        m_tvalid_next  = 1'b1;
                        out_bin_next   = '0;
                        out_count_next = '0;
                        out_last_next  = 1'b1;
                        if (have_prev_reg && unsorted) begin
                            out_status_next = drh_pkg::STATUS_UNSORTED;
                            out_total_next  = read_total_reg;
                        end else begin
                            if (!have_prev_reg) begin
                                run_length_next = 32'd1;
                                have_prev_next  = 1'b1;
                            end else if (read_match) begin
                                run_length_next = drh_pkg::sat_inc32(run_length_reg);
                            end else begin
                                hist_req.en     = 1'b1;
                                hist_req.inc    = 1'b1;
                                hist_req.addr   = drh_pkg::bin_of(run_length_reg);
                                run_length_next = 32'd1;
                            end
                            prev_chrom_next = in_chrom;
                            prev_start_next = in_start;
                            prev_end_next   = in_end;
                            read_total_next = read_total_inc;
                            out_status_next = drh_pkg::STATUS_ACCEPTED;
                            out_total_next  = read_total_inc;
                        end
                    end
                end
            end
            S_DUMP_RD: begin
                hist_req.en   = 1'b1;
                hist_req.inc  = 1'b0;
                hist_req.addr = dump_idx_reg;
                state_next    = S_DUMP_OUT;
            end
            S_DUMP_OUT: begin
                if (out_free) begin
                    m_tvalid_next   = 1'b1;
                    out_status_next = drh_pkg::STATUS_BIN;
                    out_bin_next    = 6'(dump_idx_reg);
                    out_count_next  = drh_pkg::count_out(hist_count);
                    out_total_next  = read_total_reg;
                    out_last_next   = dump_last;
                    if (dump_last) begin
                        prev_chrom_next = '0;
                        prev_start_next = '0;
                        prev_end_next   = '0;
                        have_prev_next  = 1'b0;
                        run_length_next = '0;
                        read_total_next = '0;
                        hist_clear      = 1'b1;
                        state_next      = S_RUN;
                    end else begin
                        dump_idx_next = dump_idx_reg + drh_pkg::BIN_BITS'(1);
                        state_next    = S_DUMP_RD;
                    end
                end
            end
            default: begin
                state_next = S_RUN;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg       <= S_RUN;
            paired_mode_reg <= 1'b0;
            prev_chrom_reg  <= '0;
            prev_start_reg  <= '0;
            prev_end_reg    <= '0;
            have_prev_reg   <= 1'b0;
            run_length_reg  <= '0;
            read_total_reg  <= '0;
            dump_idx_reg    <= '0;
            m_tvalid_reg    <= 1'b0;
        end else begin
            state_reg       <= state_next;
            if (cfg_wr_en) begin
                paired_mode_reg <= cfg_wr_data;
            end
            prev_chrom_reg  <= prev_chrom_next;
            prev_start_reg  <= prev_start_next;
            prev_end_reg    <= prev_end_next;
            have_prev_reg   <= have_prev_next;
            run_length_reg  <= run_length_next;
            read_total_reg  <= read_total_next;
            dump_idx_reg    <= dump_idx_next;
            m_tvalid_reg    <= m_tvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        out_status_reg <= out_status_next;
        out_bin_reg    <= out_bin_next;
        out_count_reg  <= out_count_next;
        out_total_reg  <= out_total_next;
        out_last_reg   <= out_last_next;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tuser  = out_status_reg;
    assign m_tlast  = out_last_reg;
    assign m_tdata  = {2'b00, out_total_reg, out_count_reg, out_bin_reg};

`ifndef NO_ASSERTIONS
    a_flush_starts_dump: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready && (s_tuser == drh_pkg::KIND_FLUSH)) |=>
        (state_reg == S_DUMP_RD))
        else $error("flush transaction did not start the histogram dump");

    a_read_gives_result: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready && (s_tuser == drh_pkg::KIND_READ)) |=>
        (m_tvalid && m_tlast && (m_tuser != drh_pkg::STATUS_BIN)))
        else $error("read transaction without a single read result");

    a_last_bin_closes_dump: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && (m_tuser == drh_pkg::STATUS_BIN) && m_tlast) |->
        ((m_tdata[5:0] == 6'(drh_pkg::HIST_BINS - 1)) && (read_total_reg == '0) &&
         !have_prev_reg))
        else $error("dump ended on a wrong bin or without clearing the run state");
`endif

endmodule

// ===== hdl/drh_hist_mem.sv =====
// drh_hist_mem: histogram bin storage, a synchronous ram with registered read data,
// per-bin valid bits, saturating increment write back and forwarding; uses drh_pkg

module drh_hist_mem (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  drh_pkg::hist_req_t            req,
    input  logic                          clear_all,
    output logic [drh_pkg::COUNT_BITS-1:0] old_count
);

    logic [drh_pkg::COUNT_BITS-1:0] mem_array [drh_pkg::HIST_BINS];
    logic [drh_pkg::HIST_BINS-1:0]  valid_reg;
    logic [drh_pkg::COUNT_BITS-1:0] rd_data_reg;
    logic                           hit_reg;
    logic                           fwd_reg;
    logic [drh_pkg::COUNT_BITS-1:0] fwd_data_reg;
    logic                           wb_en_reg;
    logic [drh_pkg::BIN_BITS-1:0]   wb_addr_reg;
    logic [drh_pkg::COUNT_BITS-1:0] wb_value;

    // a write in the same cycle as the read wins over the stale ram word
    assign old_count = fwd_reg ? fwd_data_reg : (hit_reg ? rd_data_reg : '0);
    assign wb_value  = (old_count == '1) ? old_count
                                         : old_count + drh_pkg::COUNT_BITS'(1);

    always_ff @(posedge aclk) begin
        if (wb_en_reg) begin
            mem_array[wb_addr_reg] <= wb_value;
        end
        if (req.en) begin
            rd_data_reg <= mem_array[req.addr];
        end
    end

    always_ff @(posedge aclk) begin
        if (req.en) begin
            hit_reg      <= valid_reg[req.addr];
            fwd_reg      <= wb_en_reg && (wb_addr_reg == req.addr);
            fwd_data_reg <= wb_value;
            wb_addr_reg  <= req.addr;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wb_en_reg <= 1'b0;
            valid_reg <= '0;
        end else begin
            wb_en_reg <= req.en && req.inc;
            if (clear_all) begin
                valid_reg <= '0;
            end else if (wb_en_reg) begin
                valid_reg[wb_addr_reg] <= 1'b1;
            end
        end
    end

endmodule
